// ----- hw/rtl/sixra_pkg.sv -----
`default_nettype none

package sixra_pkg;

	// field widths fixed by the instruction format
	localparam int DATA_W       = 32;
	localparam int CMD_W        = 4;
	localparam int IDX_FIELD_W  = 3;
	localparam int NUM_REGS_DEF = 6;

	// opcodes
	localparam logic [CMD_W-1:0] OP_ADDR = 4'd0;
	localparam logic [CMD_W-1:0] OP_ADDI = 4'd1;
	localparam logic [CMD_W-1:0] OP_MULR = 4'd2;
	localparam logic [CMD_W-1:0] OP_MULI = 4'd3;
	localparam logic [CMD_W-1:0] OP_BANR = 4'd4;
	localparam logic [CMD_W-1:0] OP_BANI = 4'd5;
	localparam logic [CMD_W-1:0] OP_BORR = 4'd6;
	localparam logic [CMD_W-1:0] OP_BORI = 4'd7;
	localparam logic [CMD_W-1:0] OP_SETR = 4'd8;
	localparam logic [CMD_W-1:0] OP_SETI = 4'd9;
	localparam logic [CMD_W-1:0] OP_GTIR = 4'd10;
	localparam logic [CMD_W-1:0] OP_GTRI = 4'd11;
	localparam logic [CMD_W-1:0] OP_GTRR = 4'd12;
	localparam logic [CMD_W-1:0] OP_EQIR = 4'd13;
	localparam logic [CMD_W-1:0] OP_EQRI = 4'd14;
	localparam logic [CMD_W-1:0] OP_EQRR = 4'd15;

	// register file update produced by one executed instruction
	typedef struct packed {
		logic                   wr_en;
		logic [IDX_FIELD_W-1:0] wr_idx;
		logic [DATA_W-1:0]      wr_data;
		logic [DATA_W-1:0]      next_pc;
	} sixra_wr_t;

	// operand a names a register
	function automatic logic a_is_reg(input logic [CMD_W-1:0] cmd);
		logic r;
		case (cmd) inside
			OP_ADDR, OP_ADDI, OP_MULR, OP_MULI, OP_BANR, OP_BANI, OP_BORR, OP_BORI,
			OP_SETR, OP_GTRI, OP_GTRR, OP_EQRI, OP_EQRR: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// operand b names a register
	function automatic logic b_is_reg(input logic [CMD_W-1:0] cmd);
		logic r;
		case (cmd) inside
			OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR,
			OP_EQRR: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sixra_alu.sv -----
`default_nettype none

module sixra_alu #(
	parameter int NUM_REGS = sixra_pkg::NUM_REGS_DEF
) (
	input  wire logic [sixra_pkg::CMD_W-1:0]                      cmd,
	input  wire logic [sixra_pkg::DATA_W-1:0]                     operand_a,
	input  wire logic [sixra_pkg::DATA_W-1:0]                     operand_b,
	input  wire logic [sixra_pkg::IDX_FIELD_W-1:0]                dest_index,
	input  wire logic [sixra_pkg::IDX_FIELD_W-1:0]                bound,
	input  wire logic [NUM_REGS-1:0][sixra_pkg::DATA_W-1:0]       regs,
	input  wire logic [sixra_pkg::DATA_W-1:0]                     pc,
	output sixra_pkg::sixra_wr_t                                  wr
);
	import sixra_pkg::*;

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam logic [DATA_W-1:0] NREGS = DATA_W'(NUM_REGS);

	logic                              bound_ok;
	logic [NUM_REGS-1:0][DATA_W-1:0]   regs_m;
	logic                              a_reg;
	logic                              b_reg;
	logic                              bad;
	logic [IDX_W-1:0]                  a_idx;
	logic [IDX_W-1:0]                  b_idx;
	logic [DATA_W-1:0]                 ra;
	logic [DATA_W-1:0]                 rb;
	logic [DATA_W-1:0]                 va;
	logic [DATA_W-1:0]                 vb;
	logic [DATA_W-1:0]                 prod;
	logic [DATA_W-1:0]                 res;
	logic [DATA_W-1:0]                 pc_src;

	// program counter mirrored into the bound register before the step
	assign bound_ok = DATA_W'(bound) < NREGS;

	always_comb begin
		for (int i = 0; i < NUM_REGS; i++) begin
			if (bound_ok && (DATA_W'(bound) == DATA_W'(i))) begin
				regs_m[i] = pc;
			end else begin
				regs_m[i] = regs[i];
			end
		end
	end

	// operand kinds and index range check
	assign a_reg = a_is_reg(cmd);
	assign b_reg = b_is_reg(cmd);
	assign bad   = (DATA_W'(dest_index) >= NREGS) ||
	               (a_reg && (operand_a >= NREGS)) ||
	               (b_reg && (operand_b >= NREGS));

	assign a_idx = operand_a[IDX_W-1:0];
	assign b_idx = operand_b[IDX_W-1:0];

	// register reads
	always_comb begin
		ra = '0;
		rb = '0;
		for (int i = 0; i < NUM_REGS; i++) begin
			if (a_idx == IDX_W'(i)) begin
				ra = regs_m[i];
			end
			if (b_idx == IDX_W'(i)) begin
				rb = regs_m[i];
			end
		end
	end

	assign va   = a_reg ? ra : operand_a;
	assign vb   = b_reg ? rb : operand_b;
	assign prod = va * vb;

	// operation select
	always_comb begin
		res = '0;
		unique case (cmd) inside
			OP_ADDR, OP_ADDI: res = va + vb;
			OP_MULR, OP_MULI: res = prod;
			OP_BANR, OP_BANI: res = va & vb;
			OP_BORR, OP_BORI: res = va | vb;
			OP_SETR, OP_SETI: res = va;
			OP_GTIR, OP_GTRI, OP_GTRR: res = DATA_W'($signed(va) > $signed(vb));
			OP_EQIR, OP_EQRI, OP_EQRR: res = DATA_W'(va == vb);
		endcase
	end

	// next pc comes from the bound register after the write
	always_comb begin
		if (!bound_ok) begin
			pc_src = pc;
		end else if (!bad && (dest_index == bound)) begin
			pc_src = res;
		end else begin
			pc_src = pc;
		end
	end

	assign wr.wr_en   = !bad;
	assign wr.wr_idx  = dest_index;
	assign wr.wr_data = bad ? '0 : res;
	assign wr.next_pc = pc_src + DATA_W'(1);

endmodule

`default_nettype wire

// ----- hw/rtl/sixra_regs.sv -----
`default_nettype none

module sixra_regs #(
	parameter int NUM_REGS = sixra_pkg::NUM_REGS_DEF
) (
	input  wire logic                                             clk,
	input  wire logic                                             arst_n,
	input  wire logic                                             step,
	input  wire logic [sixra_pkg::IDX_FIELD_W-1:0]                bound,
	input  sixra_pkg::sixra_wr_t                                  wr,
	output logic [NUM_REGS-1:0][sixra_pkg::DATA_W-1:0]            regs,
	output logic [sixra_pkg::DATA_W-1:0]                          pc
);
	import sixra_pkg::*;

	logic [NUM_REGS-1:0][DATA_W-1:0] regs_q;
	logic [DATA_W-1:0]               pc_q;

	// register file: destination write wins over the pc mirror
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
			pc_q   <= '0;
		end else if (step) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (wr.wr_en && (DATA_W'(wr.wr_idx) == DATA_W'(i))) begin
					regs_q[i] <= wr.wr_data;
				end else if (DATA_W'(bound) == DATA_W'(i)) begin
					regs_q[i] <= pc_q;
				end
			end
			pc_q <= wr.next_pc;
		end
	end

	assign regs = regs_q;
	assign pc   = pc_q;

endmodule

`default_nettype wire

// ----- hw/rtl/six_register_alu_executor.sv -----
// Six-register ALU executor.
// Each request on the input channel (in_valid / in_stall) is one instruction:
// cmd, operand_a, operand_b, dest_index. Each yields exactly one request on
// the output channel (out_valid / out_stall): next_pc, written_value and
// bad_index, in instruction order.
// The bound register index is written through cfg_we / cfg_wdata; the user must
// write it only while the block is idle, and the block does not enforce this. It
// takes effect for the next instruction. An accepted instruction is held in the
// input register, executed against the register file and pc, and its result is
// captured in the result register, from which the output channel takes it.
// Throughput: one instruction per cycle unless out_stall holds the result. The register
// file, pc and result register are all updated at the same edge, so the next
// instruction sees the previous one's writes without any bubble.
// When out_stall holds the result, the instruction in the input register
// waits and in_stall rises only if that register is occupied.
// Reset (arst_n low) clears the registers, the pc, the bound index and both
// valid flags.
`default_nettype none

module six_register_alu_executor #(
	parameter int NUM_REGS = sixra_pkg::NUM_REGS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [sixra_pkg::IDX_FIELD_W-1:0]    cfg_wdata,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [sixra_pkg::CMD_W-1:0]          cmd,
	input  wire logic signed [sixra_pkg::DATA_W-1:0]  operand_a,
	input  wire logic signed [sixra_pkg::DATA_W-1:0]  operand_b,
	input  wire logic [sixra_pkg::IDX_FIELD_W-1:0]    dest_index,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [sixra_pkg::DATA_W-1:0]       next_pc,
	output logic signed [sixra_pkg::DATA_W-1:0]       written_value,
	output logic                                      bad_index
);
	import sixra_pkg::*;

	logic [IDX_FIELD_W-1:0]          pc_bound_q;
	logic                            valid_s1;
	logic [CMD_W-1:0]                cmd_s1;
	logic [DATA_W-1:0]               operand_a_s1;
	logic [DATA_W-1:0]               operand_b_s1;
	logic [IDX_FIELD_W-1:0]          dest_index_s1;
	logic                            valid_s2;
	logic [DATA_W-1:0]               next_pc_s2;
	logic [DATA_W-1:0]               written_value_s2;
	logic                            bad_index_s2;
	logic                            advance;
	logic                            in_take;
	logic [NUM_REGS-1:0][DATA_W-1:0] regs;
	logic [DATA_W-1:0]               pc;
	sixra_wr_t                       wr;

	// handshake control
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	// bound register configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_bound_q <= '0;
		end else if (cfg_we) begin
			pc_bound_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_s1        <= cmd;
			operand_a_s1  <= operand_a;
			operand_b_s1  <= operand_b;
			dest_index_s1 <= dest_index;
		end
	end

	// execute
	sixra_alu #(
		.NUM_REGS(NUM_REGS)
	) u_alu (
		.cmd       (cmd_s1),
		.operand_a (operand_a_s1),
		.operand_b (operand_b_s1),
		.dest_index(dest_index_s1),
		.bound     (pc_bound_q),
		.regs      (regs),
		.pc        (pc),
		.wr        (wr)
	);

	// architectural state
	sixra_regs #(
		.NUM_REGS(NUM_REGS)
	) u_regs (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.bound (pc_bound_q),
		.wr    (wr),
		.regs  (regs),
		.pc    (pc)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			next_pc_s2       <= wr.next_pc;
			written_value_s2 <= wr.wr_data;
			bad_index_s2     <= !wr.wr_en;
		end
	end

	assign out_valid     = valid_s2;
	assign next_pc       = next_pc_s2;
	assign written_value = written_value_s2;
	assign bad_index     = bad_index_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/sixra_checker.sv -----
`default_nettype none

module sixra_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 cfg_we,
	input wire logic [sixra_pkg::IDX_FIELD_W-1:0]    cfg_wdata,
	input wire logic                                 in_valid,
	input wire logic                                 in_stall,
	input wire logic [sixra_pkg::CMD_W-1:0]          cmd,
	input wire logic signed [sixra_pkg::DATA_W-1:0]  operand_a,
	input wire logic signed [sixra_pkg::DATA_W-1:0]  operand_b,
	input wire logic [sixra_pkg::IDX_FIELD_W-1:0]    dest_index,
	input wire logic                                 out_valid,
	input wire logic                                 out_stall,
	input wire logic signed [sixra_pkg::DATA_W-1:0]  next_pc,
	input wire logic signed [sixra_pkg::DATA_W-1:0]  written_value,
	input wire logic                                 bad_index
);
	import sixra_pkg::*;

	// a held result keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(next_pc) &&
		$stable(written_value) && $stable(bad_index))
	else $error("stalled result changed");

	// a rejected write always reports zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_index |-> written_value == '0)
	else $error("bad index with nonzero written value");

	// with the result register empty the input is never stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
	else $error("input stalled while output empty");

	// an accepted result with nothing queued frees the input side
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !in_stall |=> !in_stall || out_valid)
	else $error("input stalled with nothing pending");

endmodule

bind six_register_alu_executor sixra_checker u_sixra_checker (.*);

`default_nettype wire

// ----- dv/sixra_exec_checker.sv -----
`default_nettype none

module sixra_exec_checker #(
	parameter int NUM_REGS = sixra_pkg::NUM_REGS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [sixra_pkg::IDX_FIELD_W-1:0] cfg_wdata,
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic [sixra_pkg::CMD_W-1:0]       cmd,
	input  wire logic [sixra_pkg::DATA_W-1:0]      operand_a,
	input  wire logic [sixra_pkg::DATA_W-1:0]      operand_b,
	input  wire logic [sixra_pkg::IDX_FIELD_W-1:0] dest_index,
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic [sixra_pkg::DATA_W-1:0]      next_pc,
	input  wire logic [sixra_pkg::DATA_W-1:0]      written_value,
	input  wire logic                              bad_index,
	output int                                     fail_count,
	output int                                     pending,
	output int                                     checked,
	output int                                     flagged
);
	timeunit 1ns;
	timeprecision 1ps;

	import sixra_pkg::*;

	localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

	typedef struct {
		logic [DATA_W-1:0] pc;
		logic [DATA_W-1:0] value;
		logic              bad;
	} exec_result_t;

	// shadow copy of the machine state
	logic [DATA_W-1:0]      regs [NUM_REGS];
	logic [DATA_W-1:0]      pc;
	logic [IDX_FIELD_W-1:0] bound;
	exec_result_t           results_due [$];

	// runs one instruction on the shadow state
	task automatic execute_instr(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic [IDX_FIELD_W-1:0] c,
			output exec_result_t r);
		logic              bound_ok;
		logic              a_reg;
		logic              b_reg;
		logic              bad;
		logic [DATA_W-1:0] va;
		logic [DATA_W-1:0] vb;
		logic [DATA_W-1:0] res;
		bound_ok = bound < NUM_REGS;
		// pc is mirrored before the instruction runs
		if (bound_ok)
			regs[IDX_W'(bound)] = pc;
		a_reg = !(op == OP_SETI || op == OP_GTIR || op == OP_EQIR);
		case (op)
			OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: b_reg = 1'b1;
			default: b_reg = 1'b0;
		endcase
		bad = (c >= NUM_REGS) || (a_reg && a >= NUM_REGS) || (b_reg && b >= NUM_REGS);
		res = '0;
		if (!bad) begin
			va = a_reg ? regs[IDX_W'(a)] : a;
			vb = b_reg ? regs[IDX_W'(b)] : b;
			case (op)
				OP_ADDR, OP_ADDI: res = va + vb;
				OP_MULR, OP_MULI: res = va * vb;
				OP_BANR, OP_BANI: res = va & vb;
				OP_BORR, OP_BORI: res = va | vb;
				OP_SETR, OP_SETI: res = va;
				OP_GTIR, OP_GTRI, OP_GTRR: res = ($signed(va) > $signed(vb)) ? 32'd1 : 32'd0;
				default: res = (va == vb) ? 32'd1 : 32'd0;
			endcase
			regs[IDX_W'(c)] = res;
		end
		r.pc = (bound_ok ? regs[IDX_W'(bound)] : pc) + 32'd1;
		r.value = res;
		r.bad = bad;
		pc = r.pc;
	endtask

	// one field of a result request
	task automatic check_field(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			if (fail_count < 10)
				$display("%s mismatch on result %0d: expected %h, got %h",
					what, checked, want, got);
			fail_count++;
		end
	endtask

	// track config, predict on input requests, compare on output requests
	always @(posedge clk or negedge arst_n) begin
		exec_result_t want;
		exec_result_t got_pred;
		if (!arst_n) begin
			foreach (regs[i])
				regs[i] = '0;
			pc = '0;
			bound = '0;
			results_due.delete();
			pending = 0;
		end else begin
			if (cfg_we)
				bound = cfg_wdata;
			// an output request never belongs to an instruction taken at this edge
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					if (fail_count < 10)
						$display("result with nothing expected: next_pc %h value %h bad %b",
							next_pc, written_value, bad_index);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					check_field("next_pc", want.pc, next_pc);
					check_field("written_value", want.value, written_value);
					check_field("bad_index", {31'b0, want.bad}, {31'b0, bad_index});
					if (bad_index)
						flagged++;
					checked++;
				end
			end
			if (in_valid && !in_stall) begin
				execute_instr(cmd, operand_a, operand_b, dest_index, got_pred);
				results_due.push_back(got_pred);
			end
			pending = results_due.size();
		end
	end

endmodule

`default_nettype wire

// ----- dv/six_register_alu_executor_tb.sv -----
`default_nettype none

module six_register_alu_executor_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sixra_pkg::*;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [IDX_FIELD_W-1:0]        cfg_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [CMD_W-1:0]              cmd = '0;
	logic [DATA_W-1:0]             operand_a = '0;
	logic [DATA_W-1:0]             operand_b = '0;
	logic [IDX_FIELD_W-1:0]        dest_index = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [DATA_W-1:0]      next_pc;
	logic signed [DATA_W-1:0]      written_value;
	logic                          bad_index;

	int fail_count;
	int pending;
	int checked;
	int flagged;
	int issued;
	int settings;
	bit idle_on = 1'b1;
	bit hold_req = 1'b0;

	six_register_alu_executor uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.dest_index    (dest_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.next_pc       (next_pc),
		.written_value (written_value),
		.bad_index     (bad_index)
	);

	sixra_exec_checker #(.NUM_REGS(NUM_REGS_DEF)) u_exec_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.dest_index    (dest_index),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.next_pc       (next_pc),
		.written_value (written_value),
		.bad_index     (bad_index),
		.fail_count    (fail_count),
		.pending       (pending),
		.checked       (checked),
		.flagged       (flagged)
	);

	// 100 MHz clock
	always #5ns clk = ~clk;

	// watchdog
	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

	// result side: random stall bursts, plus one long hold-off on request
	initial begin : result_stall
		int n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall = 1'b1;
				for (n = 0; n < 64; n++)
					@(negedge clk);
				out_stall = 1'b0;
				hold_req <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	// offer one instruction request and hold it until taken
	task automatic issue(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b, input logic [IDX_FIELD_W-1:0] c);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid = 1'b1;
		cmd = op;
		operand_a = a;
		operand_b = b;
		dest_index = c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		issued++;
	endtask

	// bound register write once the block has drained
	task automatic set_bound(input logic [IDX_FIELD_W-1:0] v);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		settings++;
	endtask

	// mostly in-range register indexes, otherwise edge values and noise
	function automatic logic [DATA_W-1:0] pick_operand(input bit as_reg);
		int sel;
		sel = $urandom_range(0, 15);
		if (as_reg && sel < 13)
			return $urandom_range(0, NUM_REGS_DEF - 1);
		case (sel % 5)
			0: return $urandom();
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return $urandom_range(0, 15);
			default: return 32'h0 - $urandom_range(1, 4);
		endcase
	endfunction

	task automatic random_instr();
		logic [CMD_W-1:0]       op;
		logic [IDX_FIELD_W-1:0] c;
		op = CMD_W'($urandom_range(0, 15));
		c = ($urandom_range(0, 9) < 9) ? IDX_FIELD_W'($urandom_range(0, NUM_REGS_DEF - 1)) :
			IDX_FIELD_W'($urandom_range(6, 7));
		issue(op, pick_operand(!(op == OP_SETI || op == OP_GTIR || op == OP_EQIR)),
			pick_operand(op inside {OP_ADDR, OP_MULR, OP_BANR, OP_BORR, OP_GTIR, OP_GTRR,
				OP_EQIR, OP_EQRR}), c);
	endtask

	// stimulus and verdict
	initial begin : stimulus
		logic [IDX_FIELD_W-1:0] bounds [8];
		int p;
		int k;
		bounds = '{3'd7, 3'd3, 3'd5, 3'd6, 3'd1, 3'd0, 3'd2, 3'd4};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: every opcode and the field extremes, pc mirrored in r0
		issue(OP_SETI, 32'h7fff_ffff, 32'hdead_beef, 3'd1);
		issue(OP_SETI, 32'h8000_0000, 32'h0, 3'd2);
		issue(OP_ADDR, 32'd1, 32'd1, 3'd3);
		issue(OP_ADDI, 32'd2, 32'hffff_ffff, 3'd4);
		issue(OP_MULR, 32'd1, 32'd2, 3'd5);
		issue(OP_MULI, 32'd1, 32'h7fff_ffff, 3'd3);
		issue(OP_BANR, 32'd1, 32'd2, 3'd4);
		issue(OP_BANI, 32'd1, 32'h0f0f_0f0f, 3'd4);
		issue(OP_BORR, 32'd1, 32'd2, 3'd5);
		issue(OP_BORI, 32'd3, 32'h8000_0000, 3'd5);
		// set ignores operand b even when it is no valid index
		issue(OP_SETR, 32'd2, 32'hffff_ffff, 3'd3);
		// signed compares across the sign boundary
		issue(OP_GTIR, 32'hffff_ffff, 32'd2, 3'd4);
		issue(OP_GTRI, 32'd2, 32'd0, 3'd4);
		issue(OP_GTRR, 32'd1, 32'd2, 3'd4);
		issue(OP_EQIR, 32'h7fff_ffff, 32'd1, 3'd4);
		issue(OP_EQRI, 32'd1, 32'h7fff_ffff, 3'd4);
		issue(OP_EQRR, 32'd3, 32'd2, 3'd4);
		// out of range destination and register operands
		issue(OP_ADDR, 32'd0, 32'd0, 3'd6);
		issue(OP_ADDR, 32'h8000_0000, 32'd0, 3'd1);
		issue(OP_ADDI, 32'd1, 32'd7, 3'd7);
		issue(OP_MULR, 32'd0, 32'hffff_ffff, 3'd1);
		issue(OP_EQRI, 32'd6, 32'd0, 3'd1);
		// immediates are never index-checked
		issue(OP_GTIR, 32'd6, 32'd5, 3'd1);
		// writes to the mirrored register move the pc
		issue(OP_SETI, 32'hffff_ffff, 32'hffff_ffff, 3'd0);
		issue(OP_ADDI, 32'd0, 32'd10, 3'd0);

		// random phases, one per bound register setting
		for (p = 0; p < 8; p++) begin
			set_bound(bounds[p]);
			if (p == 1)
				hold_req <= 1'b1;
			if (p == 7)
				idle_on <= 1'b0;
			for (k = 0; k < 60; k++) begin
				// drain completely once mid-phase
				if (p == 3 && k == 30) begin
					in_valid = 1'b0;
					while (pending != 0)
						@(negedge clk);
				end
				random_instr();
			end
		end
		in_valid = 1'b0;

		// drain and let the pipeline settle
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		$display("ran %0d instructions over %0d bound register settings, all 16 opcodes",
			issued, settings);
		$display("checked %0d results, %0d of them flagged a bad register index",
			checked, flagged);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
